FILE: rtl/vsb_pkg.sv
`timescale 1ns / 1ps

package vsb_pkg;

	// Frame geometry
	localparam int SEGMENTS_PER_FIELD       = 312;
	localparam int DATA_SYMBOLS_PER_SEGMENT = 828;
	localparam int FIELD_SEG_LEN            = 832;
	localparam int DATA_SEG_LEN             = DATA_SYMBOLS_PER_SEGMENT + 4;
	localparam int SEG_LEN_MAX              = (DATA_SEG_LEN > FIELD_SEG_LEN) ?
	                                          DATA_SEG_LEN : FIELD_SEG_LEN;
	localparam int POS_W                    = $clog2(SEG_LEN_MAX);
	localparam int SEG_W                    = $clog2(SEGMENTS_PER_FIELD + 1);

	// Field sync segment layout (symbol positions)
	localparam int SEG_SYNC_LEN = 4;
	localparam int PN63_A       = 515;
	localparam int PN63_B       = 578;
	localparam int PN63_C       = 641;
	localparam int MODE_START   = 704;
	localparam int RESV_START   = 728;
	localparam int TAIL_START   = 820;
	localparam int TAIL_LEN     = 12;

	// Generator seeds and mode flag pattern
	localparam logic [8:0]  LONG_SEED   = 9'h080;
	localparam logic [5:0]  SHORT_SEED  = 6'h27;
	localparam logic [23:0] MODE_BITS   = 24'h0A5F5A;
	localparam logic [6:0]  LEVEL_RESET = 7'd5;

	// One emitted symbol with its flags
	typedef struct packed {
		logic signed [7:0] out_symbol;
		logic              data_taken;
		logic              segment_start;
		logic              in_field_sync;
	} vsb_res_t;

endpackage

FILE: rtl/vsb_sym_gen.sv
`timescale 1ns / 1ps

// Symbol sequencer: counters, PN generators and tail history.
// The result for the current tick is combinational; state advances on step.
module vsb_sym_gen
	import vsb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic signed [7:0] data_symbol,
	input  logic [6:0]        sync_level,
	output vsb_res_t          res
);

	logic [POS_W-1:0]  pos_q;
	logic [SEG_W-1:0]  seg_q;
	logic              parity_q;
	logic [8:0]        long_pn_q;
	logic [5:0]        short_pn_q;
	logic signed [7:0] recent_q [TAIL_LEN];

	logic              fs;
	logic              is_sync;
	logic              in_long;
	logic              in_pn63;
	logic              in_mode;
	logic              in_resv;
	logic              in_tail;
	logic              short_reload;
	logic              short_run;
	logic [5:0]        short_cur;
	logic              short_fb;
	logic              long_fb;
	logic [4:0]        mode_idx;
	logic              pn_bit;
	logic              seg_last;
	logic [7:0]        level_pos;

	// Region decode
	assign fs       = (seg_q == '0);
	assign is_sync  = (pos_q < POS_W'(SEG_SYNC_LEN));
	assign in_long  = fs && !is_sync && (pos_q < POS_W'(PN63_A));
	assign in_pn63  = fs && (pos_q >= POS_W'(PN63_A)) && (pos_q < POS_W'(MODE_START));
	assign in_mode  = fs && (pos_q >= POS_W'(MODE_START)) && (pos_q < POS_W'(RESV_START));
	assign in_resv  = fs && (pos_q >= POS_W'(RESV_START)) && (pos_q < POS_W'(TAIL_START));
	assign in_tail  = fs && (pos_q >= POS_W'(TAIL_START));

	// Short PN restarts at each block boundary
	assign short_reload = fs && (pos_q == POS_W'(PN63_A) || pos_q == POS_W'(PN63_B) ||
	                             pos_q == POS_W'(PN63_C) || pos_q == POS_W'(RESV_START));
	assign short_run = in_pn63 || in_resv;
	assign short_cur = short_reload ? SHORT_SEED : short_pn_q;
	assign short_fb  = short_cur[0] ^ short_cur[1];
	assign long_fb   = long_pn_q[0] ^ long_pn_q[1] ^ long_pn_q[3] ^ long_pn_q[4] ^
	                   long_pn_q[6] ^ long_pn_q[7];

	assign mode_idx  = 5'(pos_q - POS_W'(MODE_START));
	assign level_pos = {1'b0, sync_level};
	assign seg_last  = fs ? (pos_q == POS_W'(FIELD_SEG_LEN - 1)) :
	                        (pos_q == POS_W'(DATA_SEG_LEN - 1));

	// Symbol selection
	always_comb begin
		pn_bit = 1'b0;
		priority if (is_sync) begin
			pn_bit = (pos_q == POS_W'(0)) || (pos_q == POS_W'(3));
		end else if (in_long) begin
			pn_bit = long_pn_q[0];
		end else if (in_pn63) begin
			pn_bit = short_cur[0] ^ (parity_q && (pos_q >= POS_W'(PN63_B)) &&
			                         (pos_q < POS_W'(PN63_C)));
		end else if (in_mode) begin
			pn_bit = MODE_BITS[5'd23 - mode_idx];
		end else if (in_resv) begin
			pn_bit = short_cur[0];
		end else begin
			// data symbols and tail replay carry no generator bit
			pn_bit = 1'b0;
		end

		res.data_taken    = !fs && !is_sync;
		res.segment_start = (pos_q == '0);
		res.in_field_sync = fs;
		if (res.data_taken) begin
			res.out_symbol = data_symbol;
		end else if (in_tail) begin
			res.out_symbol = recent_q[0];
		end else begin
			res.out_symbol = pn_bit ? level_pos : (8'd0 - level_pos);
		end
	end

	// Counters and generators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			seg_q      <= '0;
			parity_q   <= 1'b0;
			long_pn_q  <= LONG_SEED;
			short_pn_q <= SHORT_SEED;
		end else if (step) begin
			if (seg_last) begin
				pos_q <= '0;
				if (seg_q == SEG_W'(SEGMENTS_PER_FIELD)) begin
					seg_q    <= '0;
					parity_q <= !parity_q;
				end else begin
					seg_q <= seg_q + SEG_W'(1);
				end
			end else begin
				pos_q <= pos_q + POS_W'(1);
			end
			if (fs && pos_q == '0) begin
				long_pn_q <= LONG_SEED;
			end else if (in_long) begin
				long_pn_q <= {long_fb, long_pn_q[8:1]};
			end
			if (short_run) begin
				short_pn_q <= {short_fb, short_cur[5:1]};
			end
		end
	end

	// Tail history: shift in on data, rotate while replaying
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TAIL_LEN; i++) begin
				recent_q[i] <= '0;
			end
		end else if (step && (res.data_taken || in_tail)) begin
			for (int i = 0; i < TAIL_LEN - 1; i++) begin
				recent_q[i] <= recent_q[i + 1];
			end
			recent_q[TAIL_LEN - 1] <= res.data_taken ? data_symbol : recent_q[0];
		end
	end

endmodule

FILE: rtl/vsb_sync_inserter.sv
`timescale 1ns / 1ps

// A result is registered in the output register, or in the skid register while the output is stalled.
// Throughput: one request per cycle while in_stall is low; the sequencer advances once per accepted request.
// A skid register behind the output register lets one more request in while out_stall is high.
// Reset (arst_n low, asynchronous): field sync first, odd field, PN seeds loaded,
// tail history zero, sync_level = 5, output empty.
module vsb_sync_inserter
	import vsb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic signed [7:0] data_symbol,
	output logic              out_valid,
	input  logic              out_stall,
	output logic signed [7:0] out_symbol,
	output logic              data_taken,
	output logic              segment_start,
	output logic              in_field_sync,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [6:0]        cfg_data
);

	logic [6:0] sync_level_q;
	logic       accept;
	vsb_res_t   gen_res;
	vsb_res_t   out_res_q;
	vsb_res_t   skid_res_q;
	logic       out_valid_q;
	logic       skid_valid_q;

	// Configuration register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_level_q <= LEVEL_RESET;
		end else if (cfg_valid) begin
			sync_level_q <= cfg_data;
		end
	end

	assign in_stall = skid_valid_q;
	assign accept   = in_valid && !skid_valid_q;

	vsb_sym_gen u_gen (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (accept),
		.data_symbol (data_symbol),
		.sync_level  (sync_level_q),
		.res         (gen_res)
	);

	// Output register with skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q  <= skid_valid_q || accept;
			skid_valid_q <= 1'b0;
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || !out_stall) begin
			out_res_q <= skid_valid_q ? skid_res_q : gen_res;
		end else if (accept) begin
			skid_res_q <= gen_res;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_symbol    = out_res_q.out_symbol;
	assign data_taken    = out_res_q.data_taken;
	assign segment_start = out_res_q.segment_start;
	assign in_field_sync = out_res_q.in_field_sync;

`ifndef SYNTHESIS
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds a request while output is empty");
	a_no_data_in_fs: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(data_taken && in_field_sync))
		else $error("data consumed inside field sync");
	a_no_data_at_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(data_taken && segment_start))
		else $error("data consumed on segment sync");
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall && accept) |=> skid_valid_q)
		else $error("request lost while output stalled");
`endif

endmodule

FILE: verif/tb_vsb_sync_inserter.sv
`timescale 1ns / 1ps

module tb_vsb_sync_inserter;
	import vsb_pkg::*;

	localparam int HALF_PERIOD      = 10;
	localparam int LIMIT_CYCLES     = 1_000_000;
	localparam int RANDOM_PER_PHASE = 125;
	localparam int HOLD_CYCLES      = 40;
	localparam int DRAIN_CYCLES     = 3;
	localparam int REPORT_LIMIT     = 10;
	// total requests for the whole run
	localparam int STREAM_END       = 1500;

	typedef enum logic [0:0] {ROW_ITEM, ROW_RUN} row_kind_t;

	typedef struct {
		row_kind_t         kind;
		logic signed [7:0] din;
		bit                pinned;
		vsb_res_t          want;
	} stim_row_t;

	typedef struct {
		bit       pinned;
		vsb_res_t want;
	} pin_note_t;

	logic              clk           = 1'b0;
	logic              arst_n        = 1'b0;
	logic              in_valid      = 1'b0;
	logic              in_stall;
	logic signed [7:0] data_symbol   = '0;
	logic              out_valid;
	logic              out_stall     = 1'b0;
	logic signed [7:0] out_symbol;
	logic              data_taken;
	logic              segment_start;
	logic              in_field_sync;
	logic              cfg_valid     = 1'b0;
	logic              cfg_ready;
	logic [6:0]        cfg_data      = '0;

	// sequencer copy: position, segment, parity, generators, tail history, level
	int                sym_pos    = 0;
	int                seg_idx    = 0;
	logic              even_field = 1'b0;
	logic [8:0]        long_pn    = LONG_SEED;
	logic [5:0]        short_pn   = SHORT_SEED;
	logic signed [7:0] tail_hist [TAIL_LEN];
	logic [6:0]        level_copy = LEVEL_RESET;

	vsb_res_t  symbols_due [$];
	pin_note_t pin_notes [$];

	int  items_sent     = 0;
	int  err_count      = 0;
	int  results_seen   = 0;
	int  data_count     = 0;
	int  fsync_count    = 0;
	int  in_stall_count = 0;
	int  cycles         = 0;
	bit  tx_gaps        = 1'b1;
	bit  rx_bursty      = 1'b1;
	bit  hold_req       = 1'b0;

	// after reset: field sync opening, then the first data segment with extreme symbols
	stim_row_t opening_script [20] = '{
		'{ROW_ITEM, 8'sd127,  1'b1, '{8'sd5,   1'b0, 1'b1, 1'b1}},
		'{ROW_ITEM, 8'sh80,   1'b1, '{-8'sd5,  1'b0, 1'b0, 1'b1}},
		'{ROW_ITEM, 8'sd0,    1'b1, '{-8'sd5,  1'b0, 1'b0, 1'b1}},
		'{ROW_ITEM, -8'sd1,   1'b1, '{8'sd5,   1'b0, 1'b0, 1'b1}},
		'{ROW_ITEM, 8'sh55,   1'b0, '0},
		'{ROW_ITEM, 8'shAA,   1'b0, '0},
		'{ROW_RUN,  8'sd0,    1'b0, '0},
		'{ROW_ITEM, 8'sh80,   1'b1, '{8'sd5,   1'b0, 1'b1, 1'b0}},
		'{ROW_ITEM, 8'sd127,  1'b1, '{-8'sd5,  1'b0, 1'b0, 1'b0}},
		'{ROW_ITEM, 8'sh55,   1'b1, '{-8'sd5,  1'b0, 1'b0, 1'b0}},
		'{ROW_ITEM, 8'sd1,    1'b1, '{8'sd5,   1'b0, 1'b0, 1'b0}},
		'{ROW_ITEM, 8'sh80,   1'b1, '{8'sh80,  1'b1, 1'b0, 1'b0}},
		'{ROW_ITEM, 8'sd127,  1'b1, '{8'sd127, 1'b1, 1'b0, 1'b0}},
		'{ROW_ITEM, 8'sd0,    1'b1, '{8'sd0,   1'b1, 1'b0, 1'b0}},
		'{ROW_ITEM, -8'sd1,   1'b1, '{-8'sd1,  1'b1, 1'b0, 1'b0}},
		'{ROW_ITEM, 8'sd1,    1'b1, '{8'sd1,   1'b1, 1'b0, 1'b0}},
		'{ROW_ITEM, 8'sh55,   1'b1, '{8'sh55,  1'b1, 1'b0, 1'b0}},
		'{ROW_ITEM, 8'shAA,   1'b1, '{8'shAA,  1'b1, 1'b0, 1'b0}},
		'{ROW_ITEM, -8'sd2,   1'b1, '{-8'sd2,  1'b1, 1'b0, 1'b0}},
		'{ROW_ITEM, 8'sd64,   1'b1, '{8'sd64,  1'b1, 1'b0, 1'b0}}
	};

	vsb_sync_inserter dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.data_symbol   (data_symbol),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_symbol    (out_symbol),
		.data_taken    (data_taken),
		.segment_start (segment_start),
		.in_field_sync (in_field_sync),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	// +level for a one bit, -level for a zero bit
	function automatic logic signed [7:0] level_sym(input logic b);
		logic [7:0] mag;
		mag = {1'b0, level_copy};
		return b ? mag : (~mag + 8'd1);
	endfunction

	function automatic logic short_pn_shift();
		logic b;
		b = short_pn[0];
		short_pn = {short_pn[0] ^ short_pn[1], short_pn[5:1]};
		return b;
	endfunction

	// next emitted symbol; advances the sequencer copy by one tick
	function automatic vsb_res_t next_vsb_symbol(input logic signed [7:0] din);
		vsb_res_t r;
		logic     b;
		logic     fsync;
		int       seg_len;
		fsync   = (seg_idx == 0);
		seg_len = fsync ? FIELD_SEG_LEN : DATA_SEG_LEN;
		r.out_symbol    = '0;
		r.data_taken    = 1'b0;
		r.segment_start = (sym_pos == 0);
		r.in_field_sync = fsync;
		if (sym_pos < SEG_SYNC_LEN) begin
			r.out_symbol = level_sym(sym_pos == 0 || sym_pos == 3);
			if (fsync && sym_pos == 0)
				long_pn = LONG_SEED;
		end else if (fsync) begin
			if (sym_pos == PN63_A || sym_pos == PN63_B || sym_pos == PN63_C ||
			    sym_pos == RESV_START)
				short_pn = SHORT_SEED;
			if (sym_pos < PN63_A) begin
				b = long_pn[0];
				long_pn = {^{long_pn[0], long_pn[1], long_pn[3], long_pn[4],
				             long_pn[6], long_pn[7]}, long_pn[8:1]};
				r.out_symbol = level_sym(b);
			end else if (sym_pos < MODE_START) begin
				b = short_pn_shift();
				// middle PN63 block flips on even fields
				if (even_field && sym_pos >= PN63_B && sym_pos < PN63_C)
					b = ~b;
				r.out_symbol = level_sym(b);
			end else if (sym_pos < RESV_START) begin
				r.out_symbol = level_sym(MODE_BITS[23 - (sym_pos - MODE_START)]);
			end else if (sym_pos < TAIL_START) begin
				r.out_symbol = level_sym(short_pn_shift());
			end else begin
				r.out_symbol = tail_hist[(sym_pos - TAIL_START) % TAIL_LEN];
			end
		end else begin
			r.out_symbol = din;
			r.data_taken = 1'b1;
			for (int k = 0; k < TAIL_LEN - 1; k++)
				tail_hist[k] = tail_hist[k + 1];
			tail_hist[TAIL_LEN - 1] = din;
		end
		sym_pos++;
		if (sym_pos >= seg_len) begin
			sym_pos = 0;
			seg_idx++;
			if (seg_idx > SEGMENTS_PER_FIELD) begin
				seg_idx    = 0;
				even_field = ~even_field;
			end
		end
		return r;
	endfunction

	// mostly uniform, sometimes an extreme value
	function automatic logic signed [7:0] rand_symbol();
		logic signed [7:0] picks [4];
		picks = '{8'sh80, 8'sd127, 8'sd0, -8'sd1};
		if ($urandom_range(0, 7) == 0)
			return picks[$urandom_range(0, 3)];
		return 8'($urandom_range(0, 255));
	endfunction

	// offer one request, with an optional idle burst first
	task automatic offer(input logic signed [7:0] din, input bit pinned, input vsb_res_t want);
		int        gap;
		pin_note_t note;
		if (tx_gaps && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 4);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		note.pinned = pinned;
		note.want   = want;
		pin_notes   = {pin_notes, note};
		in_valid    <= 1'b1;
		data_symbol <= din;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
	endtask

	// one edge first so the last accepted request is already queued
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (symbols_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_level(input logic [6:0] lvl);
		cfg_valid <= 1'b1;
		cfg_data  <= lvl;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d requests accepted", cycles, items_sent);
			$display("tb_vsb_sync_inserter: errors");
			$finish;
		end
	end

	// receiver: random stall bursts, plus one long hold on request
	initial begin
		int n;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
			end else if (rx_bursty && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 4);
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// monitor: register writes, accepted requests, and result checks
	always @(posedge clk) begin
		vsb_res_t  got;
		vsb_res_t  want;
		pin_note_t note;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				level_copy = cfg_data;
			if (in_valid && in_stall)
				in_stall_count++;
			// check before queuing this edge's request
			if (out_valid && !out_stall) begin
				got = '{out_symbol, data_taken, segment_start, in_field_sync};
				results_seen++;
				if (got.data_taken)
					data_count++;
				if (got.segment_start && got.in_field_sync)
					fsync_count++;
				if (symbols_due.size() == 0) begin
					err_count++;
					if (err_count <= REPORT_LIMIT)
						$display("result %0d with nothing outstanding: symbol %0d",
						         results_seen, got.out_symbol);
				end else begin
					want = symbols_due.pop_front();
					if (got.out_symbol !== want.out_symbol ||
					    got.data_taken !== want.data_taken ||
					    got.segment_start !== want.segment_start ||
					    got.in_field_sync !== want.in_field_sync) begin
						err_count++;
						if (err_count <= REPORT_LIMIT)
							$display({"result %0d mismatch (exp/act): symbol %0d/%0d ",
							          "taken %b/%b start %b/%b fsync %b/%b"},
							         results_seen, want.out_symbol, got.out_symbol,
							         want.data_taken, got.data_taken,
							         want.segment_start, got.segment_start,
							         want.in_field_sync, got.in_field_sync);
					end
				end
			end
			if (in_valid && !in_stall) begin
				want = next_vsb_symbol(data_symbol);
				note = pin_notes.pop_front();
				if (note.pinned)
					want = note.want;
				symbols_due = {symbols_due, want};
			end
		end
	end

	// stimulus
	initial begin
		logic [6:0] phase_levels [4];
		foreach (tail_hist[k])
			tail_hist[k] = '0;
		phase_levels = '{7'd127, 7'd0, 7'($urandom_range(1, 126)), 7'($urandom_range(1, 126))};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: opening of the first field, then the first data segment
		foreach (opening_script[i]) begin
			if (opening_script[i].kind == ROW_RUN) begin
				while (items_sent < FIELD_SEG_LEN)
					offer(rand_symbol(), 1'b0, '0);
			end else begin
				offer(opening_script[i].din, opening_script[i].pinned, opening_script[i].want);
			end
		end
		drain();

		// random data at several levels; one phase starts with a long output hold
		for (int p = 0; p < 4; p++) begin
			write_level(phase_levels[p]);
			if (p == 1)
				hold_req = 1'b1;
			for (int n = 0; n < RANDOM_PER_PHASE; n++)
				offer(rand_symbol(), 1'b0, '0);
			drain();
		end

		// full rate to the end of the run
		tx_gaps   = 1'b0;
		rx_bursty = 1'b0;
		write_level(7'd127);
		while (items_sent < STREAM_END)
			offer(rand_symbol(), 1'b0, '0);
		drain();

		$display("covered %0d requests, %0d data symbols, %0d field sync segment(s)",
		         items_sent, data_count, fsync_count);
		$display("levels 5, 0, 127 and two random; input held off for %0d cycles", in_stall_count);
		if (err_count == 0) begin
			$display("tb_vsb_sync_inserter: clean");
		end else begin
			$display("%0d failed results", err_count);
			$display("tb_vsb_sync_inserter: errors");
		end
		$finish;
	end

endmodule
